// ===== rtl/bfsp_pkg.sv =====
`timescale 1ns / 1ps

package bfsp_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_EDGES_DEF    = 256;
	localparam int WEIGHT_BITS_DEF  = 32;
	localparam int DIST_BITS        = 40;
	localparam int VID_BITS         = 6;
	localparam int VC_BITS          = 7;
	localparam logic [VC_BITS-1:0] VC_RESET = 7'd64;

	typedef enum logic [1:0] {
		MODE_EDGE   = 2'd0,
		MODE_SOURCE = 2'd1,
		MODE_RUN    = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		PH_RELAX,
		PH_DETECT,
		PH_PROP
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_VRD,
		ST_EVAL,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	typedef struct packed {
		mode_t                 mode;
		logic [VID_BITS-1:0]   edge_from;
		logic [VID_BITS-1:0]   edge_to;
		logic signed [31:0]    edge_weight;
		logic [VID_BITS-1:0]   source_vertex;
	} cmd_t;

	typedef struct packed {
		logic [VID_BITS-1:0]         vertex;
		logic                        reachable;
		logic signed [DIST_BITS-1:0] distance;
		logic                        has_parent;
		logic [VID_BITS-1:0]         parent_vertex;
		logic                        in_neg_cycle;
		logic                        any_neg_cycle;
		logic                        edges_dropped;
		logic                        last;
	} result_t;

	typedef struct packed {
		logic                        neg;
		logic                        pvalid;
		logic [VID_BITS-1:0]         pred;
		logic                        reach;
		logic signed [DIST_BITS-1:0] dist_val;
	} vword_t;

	typedef struct packed {
		logic                en;
		logic [VID_BITS-1:0] addr;
		vword_t              data;
	} vwr_t;

endpackage

// ===== rtl/bellman_ford_shortest_paths.sv =====
`timescale 1ns / 1ps

// Multi-source shortest paths over a stored edge list.
// An item is taken when start is high and busy is low. Mode 0 stores an edge,
// mode 1 marks a source vertex; both leave busy low.
// Mode 2 runs the search and raises busy until all results are out.
// A run makes up to vertex_count-1 relaxation passes, one detection pass and
// as many marking passes as needed; in every pass each stored edge goes
// through an edge read, a vertex read and an evaluate and write back step,
// and the pass ends with a closing step.
// After that, the vertices are read out in order, one result per vertex, with
// result_valid high for one cycle; last marks the final vertex. The receiver
// cannot stall, so results must be taken when shown.
// Once the last result is out, edges, distances and flags are cleared.
// cfg_we and cfg_wdata write the vertex count register; the user must write it
// only while idle, which the block does not enforce. Reset sets the count to
// 64 and clears all run state at once via per-vertex valid bits, not a pass.

module bellman_ford_shortest_paths import bfsp_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_EDGES = MAX_EDGES_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  cmd_t               cmd,
	input  logic               cfg_we,
	input  logic [VC_BITS-1:0] cfg_wdata,
	output logic               result_valid,
	output result_t            result
);

	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int SW = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;
	localparam longint DIST_MAX_L = 64'sd549755813887;
	localparam logic signed [SW-1:0] DMAX = SW'(DIST_MAX_L);
	localparam logic signed [SW-1:0] DMIN = -DMAX - SW'(1);

	state_t state_q, state_d;
	phase_t phase_q;
	logic [VC_BITS-1:0] vc_q;
	logic [VC_BITS-1:0] n;
	logic [ECW-1:0] loaded_q;
	logic [ECW-1:0] e_q;
	logic [VC_BITS-1:0] pass_q;
	logic changed_q;
	logic any_neg_q;
	logic drop_q;
	logic [VID_BITS-1:0] v_q;
	logic accept;
	logic edge_ok;
	logic edge_we;
	logic [VID_BITS-1:0] e_tail;
	logic [VID_BITS-1:0] e_head;
	logic signed [WEIGHT_BITS-1:0] e_w;
	logic signed [WEIGHT_BITS-1:0] w_in;
	vwr_t vwr;
	logic [VID_BITS-1:0] ra_addr;
	logic [VID_BITS-1:0] rb_addr;
	vword_t td;
	vword_t hd;
	logic signed [SW-1:0] sum;
	logic signed [DIST_BITS-1:0] cand;
	logic usable;
	logic relax;
	logic hit;
	logic pass_end;
	logic to_emit;
	logic is_last;

	assign n = (vc_q == '0) ? VC_BITS'(1) :
		((vc_q > VC_BITS'(MAX_VERTICES)) ? VC_BITS'(MAX_VERTICES) : vc_q);
	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign w_in = WEIGHT_BITS'(cmd.edge_weight);
	assign edge_ok = ({1'b0, cmd.edge_from} < n) && ({1'b0, cmd.edge_to} < n)
		&& (loaded_q < ECW'(MAX_EDGES));
	assign edge_we = accept && (cmd.mode == MODE_EDGE) && edge_ok;

	bfsp_edge_mem #(
		.DEPTH(MAX_EDGES),
		.WB(WEIGHT_BITS)
	) u_edge_mem (
		.clk(clk),
		.we(edge_we),
		.waddr(loaded_q[EAW-1:0]),
		.wtail(cmd.edge_from),
		.whead(cmd.edge_to),
		.wweight(w_in),
		.raddr(e_q[EAW-1:0]),
		.rtail(e_tail),
		.rhead(e_head),
		.rweight(e_w)
	);

	bfsp_vert_mem #(
		.DEPTH(MAX_VERTICES)
	) u_vert_mem (
		.clk(clk),
		.arst_n(arst_n),
		.clr(state_q == ST_EMIT_OUT && is_last),
		.wr(vwr),
		.ra_addr(ra_addr),
		.rb_addr(rb_addr),
		.ra_data(td),
		.rb_data(hd)
	);

	always_comb begin
		sum = SW'(td.dist_val) + SW'(e_w);
		if (sum > DMAX) begin
			cand = DIST_BITS'(DMAX);
		end else if (sum < DMIN) begin
			cand = DIST_BITS'(DMIN);
		end else begin
			cand = sum[DIST_BITS-1:0];
		end
		usable = ({1'b0, e_tail} < n) && ({1'b0, e_head} < n);
		relax = td.reach && (!hd.reach || (cand < hd.dist_val));
		case (phase_q)
			PH_RELAX, PH_DETECT: hit = usable && relax;
			PH_PROP: hit = usable && td.neg && !hd.neg;
			default: hit = 1'b0;
		endcase
		pass_end = (e_q == loaded_q);
		case (phase_q)
			PH_DETECT: to_emit = !any_neg_q;
			PH_PROP: to_emit = !changed_q;
			default: to_emit = 1'b0;
		endcase
		is_last = ({1'b0, v_q} + VC_BITS'(1)) == n;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd.mode == MODE_RUN) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!pass_end) begin
					state_d = ST_VRD;
				end else if (to_emit) begin
					state_d = ST_EMIT_RD;
				end
			end
			ST_VRD: state_d = ST_EVAL;
			ST_EVAL: state_d = ST_SCAN;
			ST_EMIT_RD: state_d = ST_EMIT_OUT;
			ST_EMIT_OUT: state_d = is_last ? ST_IDLE : ST_EMIT_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		vwr = '0;
		ra_addr = e_tail;
		rb_addr = e_head;
		result_valid = 1'b0;
		result = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd.mode == MODE_SOURCE && ({1'b0, cmd.source_vertex} < n)) begin
					vwr.en = 1'b1;
					vwr.addr = cmd.source_vertex;
					vwr.data = '0;
					vwr.data.reach = 1'b1;
				end
			end
			ST_EVAL: begin
				vwr.en = hit;
				vwr.addr = e_head;
				vwr.data = hd;
				case (phase_q)
					PH_RELAX: begin
						vwr.data.dist_val = cand;
						vwr.data.reach = 1'b1;
						vwr.data.pvalid = 1'b1;
						vwr.data.pred = e_tail;
					end
					default: vwr.data.neg = 1'b1;
				endcase
			end
			ST_EMIT_RD: ra_addr = v_q;
			ST_EMIT_OUT: begin
				ra_addr = v_q;
				result_valid = 1'b1;
				result.vertex = v_q;
				result.reachable = td.reach;
				result.distance = td.reach ? td.dist_val : '0;
				result.has_parent = td.pvalid;
				result.parent_vertex = td.pvalid ? td.pred : '0;
				result.in_neg_cycle = td.neg;
				result.any_neg_cycle = any_neg_q;
				result.edges_dropped = drop_q;
				result.last = is_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_RELAX;
			vc_q <= VC_RESET;
			loaded_q <= '0;
			e_q <= '0;
			pass_q <= '0;
			changed_q <= 1'b0;
			any_neg_q <= 1'b0;
			drop_q <= 1'b0;
			v_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				vc_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && cmd.mode == MODE_EDGE) begin
						if (edge_ok) begin
							loaded_q <= loaded_q + ECW'(1);
						end else begin
							drop_q <= 1'b1;
						end
					end
					if (accept && cmd.mode == MODE_RUN) begin
						phase_q <= (n > VC_BITS'(1)) ? PH_RELAX : PH_DETECT;
						e_q <= '0;
						pass_q <= '0;
						changed_q <= 1'b0;
						any_neg_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (pass_end) begin
						e_q <= '0;
						changed_q <= 1'b0;
						v_q <= '0;
						case (phase_q)
							PH_RELAX: begin
								if (changed_q && ({1'b0, pass_q} + 8'd2 < {1'b0, n})) begin
									pass_q <= pass_q + VC_BITS'(1);
								end else begin
									phase_q <= PH_DETECT;
								end
							end
							PH_DETECT: begin
								if (any_neg_q) begin
									phase_q <= PH_PROP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_EVAL: begin
					e_q <= e_q + ECW'(1);
					if (hit) begin
						if (phase_q == PH_DETECT) begin
							any_neg_q <= 1'b1;
						end else begin
							changed_q <= 1'b1;
						end
					end
				end
				ST_EMIT_OUT: begin
					v_q <= v_q + VID_BITS'(1);
					if (is_last) begin
						loaded_q <= '0;
						drop_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	a_result_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result shown while idle");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |=> !busy)
		else $error("run did not end after the last item");

	a_idle_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && vwr.en) |-> (start && cmd.mode == MODE_SOURCE))
		else $error("vertex store written while idle without a source item");

	a_no_write_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_RD || state_q == ST_EMIT_OUT) |-> !vwr.en && !edge_we)
		else $error("store written while results go out");

	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= ECW'(MAX_EDGES))
		else $error("edge count beyond capacity");

endmodule

// ===== rtl/bfsp_edge_mem.sv =====
`timescale 1ns / 1ps

module bfsp_edge_mem import bfsp_pkg::*; #(
	parameter int DEPTH = MAX_EDGES_DEF,
	parameter int WB = WEIGHT_BITS_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [VID_BITS-1:0]        wtail,
	input  logic [VID_BITS-1:0]        whead,
	input  logic signed [WB-1:0]       wweight,
	input  logic [AW-1:0]              raddr,
	output logic [VID_BITS-1:0]        rtail,
	output logic [VID_BITS-1:0]        rhead,
	output logic signed [WB-1:0]       rweight
);

	localparam int EW = 2 * VID_BITS + WB;

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wtail, whead, wweight};
		end
		rd_q <= mem[raddr];
	end

	assign rtail   = rd_q[EW-1 -: VID_BITS];
	assign rhead   = rd_q[WB +: VID_BITS];
	assign rweight = $signed(rd_q[WB-1:0]);

endmodule

// ===== rtl/bfsp_vert_mem.sv =====
`timescale 1ns / 1ps

module bfsp_vert_mem import bfsp_pkg::*; #(
	parameter int DEPTH = MAX_VERTICES_DEF,
	localparam int VA = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  vwr_t                wr,
	input  logic [VID_BITS-1:0] ra_addr,
	input  logic [VID_BITS-1:0] rb_addr,
	output vword_t              ra_data,
	output vword_t              rb_data
);

	vword_t mem [DEPTH];
	vword_t ra_q;
	vword_t rb_q;
	logic [DEPTH-1:0] valid_q;
	logic ra_v_q;
	logic rb_v_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[VA-1:0]] <= wr.data;
		end
		ra_q <= mem[ra_addr[VA-1:0]];
		rb_q <= mem[rb_addr[VA-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ra_v_q <= 1'b0;
			rb_v_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (wr.en) begin
				valid_q[wr.addr[VA-1:0]] <= 1'b1;
			end
			ra_v_q <= valid_q[ra_addr[VA-1:0]];
			rb_v_q <= valid_q[rb_addr[VA-1:0]];
		end
	end

	assign ra_data = ra_v_q ? ra_q : '0;
	assign rb_data = rb_v_q ? rb_q : '0;

endmodule

// ===== tb/bfsp_checker.sv =====
`timescale 1ns / 1ps

module bfsp_checker import bfsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  cmd_t               cmd,
	input  logic               cfg_we,
	input  logic [VC_BITS-1:0] cfg_wdata,
	input  logic               result_valid,
	input  result_t            result,
	output int                 pending,
	output int                 fails
);

	localparam longint DIST_TOP = 64'sd549755813887;
	localparam longint DIST_BOTTOM = -DIST_TOP - 1;

	logic [VID_BITS-1:0] arc_tail [MAX_EDGES_DEF];
	logic [VID_BITS-1:0] arc_head [MAX_EDGES_DEF];
	longint              arc_weight [MAX_EDGES_DEF];
	int                  arc_count;
	longint              best_dist [MAX_VERTICES_DEF];
	bit                  reach [MAX_VERTICES_DEF];
	bit                  pred_ok [MAX_VERTICES_DEF];
	logic [VID_BITS-1:0] pred [MAX_VERTICES_DEF];
	bit                  neg [MAX_VERTICES_DEF];
	bit                  dropped;
	logic [VC_BITS-1:0]  vcount;
	result_t             expected_results [$];
	int                  errors;

	function automatic int used_vertices();
		if (vcount == 0)
			return 1;
		if (vcount > MAX_VERTICES_DEF)
			return MAX_VERTICES_DEF;
		return vcount;
	endfunction

	function automatic longint clamp_sum(longint a, longint b);
		longint s;
		s = a + b;
		if (s > DIST_TOP)
			return DIST_TOP;
		if (s < DIST_BOTTOM)
			return DIST_BOTTOM;
		return s;
	endfunction

	function automatic bit arc_in_range(int e, int n);
		return arc_tail[e] < n && arc_head[e] < n;
	endfunction

	function automatic bit relaxes(int e, output longint cand);
		cand = 0;
		if (!reach[arc_tail[e]])
			return 0;
		cand = clamp_sum(best_dist[arc_tail[e]], arc_weight[e]);
		return !reach[arc_head[e]] || cand < best_dist[arc_head[e]];
	endfunction

	task automatic clear_graph();
		arc_count = 0;
		dropped = 0;
		for (int v = 0; v < MAX_VERTICES_DEF; v++) begin
			best_dist[v] = 0;
			reach[v] = 0;
			pred_ok[v] = 0;
			pred[v] = 0;
			neg[v] = 0;
		end
	endtask

	task automatic run_search();
		int n;
		bit changed;
		bit any_neg;
		longint cand;
		result_t r;
		n = used_vertices();
		any_neg = 0;
		for (int p = 0; p + 1 < n; p++) begin
			changed = 0;
			for (int e = 0; e < arc_count; e++) begin
				if (arc_in_range(e, n) && relaxes(e, cand)) begin
					best_dist[arc_head[e]] = cand;
					reach[arc_head[e]] = 1;
					pred_ok[arc_head[e]] = 1;
					pred[arc_head[e]] = arc_tail[e];
					changed = 1;
				end
			end
			if (!changed)
				break;
		end
		for (int e = 0; e < arc_count; e++) begin
			if (arc_in_range(e, n) && relaxes(e, cand)) begin
				neg[arc_head[e]] = 1;
				any_neg = 1;
			end
		end
		if (any_neg) begin
			do begin
				changed = 0;
				for (int e = 0; e < arc_count; e++) begin
					if (arc_in_range(e, n) && neg[arc_tail[e]] && !neg[arc_head[e]]) begin
						neg[arc_head[e]] = 1;
						changed = 1;
					end
				end
			end while (changed);
		end
		for (int v = 0; v < n; v++) begin
			r.vertex = VID_BITS'(v);
			r.reachable = reach[v];
			r.distance = reach[v] ? best_dist[v][DIST_BITS-1:0] : '0;
			r.has_parent = pred_ok[v];
			r.parent_vertex = pred_ok[v] ? pred[v] : '0;
			r.in_neg_cycle = neg[v];
			r.any_neg_cycle = any_neg;
			r.edges_dropped = dropped;
			r.last = (v + 1 == n);
			expected_results.insert(expected_results.size(), r);
		end
		clear_graph();
	endtask

	task automatic take_item(cmd_t c);
		int n;
		n = used_vertices();
		case (c.mode)
			MODE_EDGE: begin
				if (c.edge_from >= n || c.edge_to >= n || arc_count >= MAX_EDGES_DEF) begin
					dropped = 1;
				end else begin
					arc_tail[arc_count] = c.edge_from;
					arc_head[arc_count] = c.edge_to;
					arc_weight[arc_count] = longint'($signed(c.edge_weight));
					arc_count++;
				end
			end
			MODE_SOURCE: begin
				if (c.source_vertex < n) begin
					best_dist[c.source_vertex] = 0;
					reach[c.source_vertex] = 1;
					pred_ok[c.source_vertex] = 0;
					pred[c.source_vertex] = 0;
				end
			end
			MODE_RUN:
				run_search();
			default: ;
		endcase
	endtask

	task automatic compare(result_t got);
		result_t want;
		if (expected_results.size() == 0) begin
			$error("Result for vertex %0d arrived with none expected.", got.vertex);
			errors++;
			return;
		end
		want = expected_results.pop_front();
		if (got.vertex !== want.vertex) begin
			$error("vertex: expected %0d, got %0d", want.vertex, got.vertex);
			errors++;
		end
		if (got.reachable !== want.reachable) begin
			$error("reachable: expected %0d, got %0d", want.reachable, got.reachable);
			errors++;
		end
		if (got.distance !== want.distance) begin
			$error("distance: expected %0d, got %0d", want.distance, got.distance);
			errors++;
		end
		if (got.has_parent !== want.has_parent) begin
			$error("has_parent: expected %0d, got %0d", want.has_parent, got.has_parent);
			errors++;
		end
		if (got.parent_vertex !== want.parent_vertex) begin
			$error("parent_vertex: expected %0d, got %0d", want.parent_vertex,
				got.parent_vertex);
			errors++;
		end
		if (got.in_neg_cycle !== want.in_neg_cycle) begin
			$error("in_neg_cycle: expected %0d, got %0d", want.in_neg_cycle,
				got.in_neg_cycle);
			errors++;
		end
		if (got.any_neg_cycle !== want.any_neg_cycle) begin
			$error("any_neg_cycle: expected %0d, got %0d", want.any_neg_cycle,
				got.any_neg_cycle);
			errors++;
		end
		if (got.edges_dropped !== want.edges_dropped) begin
			$error("edges_dropped: expected %0d, got %0d", want.edges_dropped,
				got.edges_dropped);
			errors++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_graph();
			vcount = VC_RESET;
			errors = 0;
			expected_results.delete();
			pending <= 0;
			fails <= 0;
		end else begin
			if (result_valid === 1'b1)
				compare(result);
			else if (result_valid !== 1'b0) begin
				$error("result_valid: expected 0 or 1, got %b", result_valid);
				errors++;
			end
			if (start && busy === 1'b0)
				take_item(cmd);
			if (cfg_we)
				vcount = cfg_wdata;
			pending <= expected_results.size();
			fails <= errors;
		end
	end

endmodule

// ===== tb/bellman_ford_shortest_paths_test.sv =====
`timescale 1ns / 1ps

module bellman_ford_shortest_paths_test import bfsp_pkg::*; ();

	localparam int CYCLE_LIMIT = 3000000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	cmd_t               cmd;
	logic               cfg_we;
	logic [VC_BITS-1:0] cfg_wdata;
	logic               result_valid;
	result_t            result;
	int                 pending;
	int                 fails;
	int                 cycles;
	int                 vc_now;

	bellman_ford_shortest_paths i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.result_valid(result_valid),
		.result(result)
	);

	bfsp_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.result_valid(result_valid),
		.result(result),
		.pending(pending),
		.fails(fails)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL bellman_ford_shortest_paths");
			$finish;
		end
	end

	function automatic int vertices_in_use();
		if (vc_now == 0)
			return 1;
		if (vc_now > MAX_VERTICES_DEF)
			return MAX_VERTICES_DEF;
		return vc_now;
	endfunction

	function automatic cmd_t noise_cmd(mode_t m);
		logic [63:0] raw;
		cmd_t c;
		raw = {$urandom, $urandom};
		c = raw[$bits(cmd_t)-1:0];
		c.mode = m;
		return c;
	endfunction

	function automatic cmd_t arc_cmd(int f, int t, int w);
		cmd_t c;
		c = noise_cmd(MODE_EDGE);
		c.edge_from = VID_BITS'(f);
		c.edge_to = VID_BITS'(t);
		c.edge_weight = w;
		return c;
	endfunction

	function automatic cmd_t source_cmd(int s);
		cmd_t c;
		c = noise_cmd(MODE_SOURCE);
		c.source_vertex = VID_BITS'(s);
		return c;
	endfunction

	function automatic int pick_weight();
		case ($urandom_range(0, 4))
			0: return int'($urandom_range(0, 20)) - 8;
			1: return int'($urandom);
			2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return int'($urandom_range(0, 50));
		endcase
	endfunction

	task automatic send(cmd_t c);
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause(int k);
		@(negedge clk);
		start <= 1'b0;
		repeat (k - 1)
			@(negedge clk);
	endtask

	task automatic send_maybe_gap(cmd_t c, bit calm);
		send(c);
		if (!calm && $urandom_range(0, 3) == 0)
			pause($urandom_range(1, 18));
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
	endtask

	task automatic set_vertex_count(int v);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= VC_BITS'(v);
		vc_now = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(bit calm);
		int n;
		int count;
		int r;
		case ($urandom_range(0, 9))
			0: set_vertex_count(64);
			1: set_vertex_count($urandom_range(0, 127));
			default: set_vertex_count($urandom_range(1, 10));
		endcase
		n = vertices_in_use();
		count = $urandom_range(4, 14);
		send_maybe_gap(source_cmd($urandom_range(0, n - 1)), calm);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 19);
			if (r < 13)
				send_maybe_gap(arc_cmd($urandom_range(0, n - 1), $urandom_range(0, n - 1),
					pick_weight()), calm);
			else if (r < 14)
				send_maybe_gap(arc_cmd($urandom_range(0, 63), $urandom_range(0, 63),
					pick_weight()), calm);
			else if (r < 18)
				send_maybe_gap(source_cmd($urandom_range(0, n - 1)), calm);
			else if (r < 19)
				send_maybe_gap(source_cmd($urandom_range(0, 63)), calm);
			else
				send_maybe_gap(noise_cmd(MODE_NOP), calm);
		end
		send_maybe_gap(noise_cmd(MODE_RUN), calm);
	endtask

	initial begin
		cycles = 0;
		vc_now = VC_RESET;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(arc_cmd(0, 63, 32'sh7fffffff));
		send(arc_cmd(63, 1, 32'sh80000000));
		send(source_cmd(0));
		send(source_cmd(63));
		send(noise_cmd(MODE_NOP));
		send(noise_cmd(MODE_RUN));

		set_vertex_count(5);
		send(arc_cmd(0, 1, 3));
		send(arc_cmd(1, 2, -1));
		send(arc_cmd(2, 1, -1));
		send(arc_cmd(2, 3, 4));
		send(arc_cmd(7, 1, 2));
		send(source_cmd(0));
		send(source_cmd(9));
		send(noise_cmd(MODE_RUN));

		set_vertex_count(8);
		send(arc_cmd(0, 6, 2));
		send(arc_cmd(6, 7, 5));
		send(arc_cmd(0, 2, 1));
		set_vertex_count(3);
		send(source_cmd(0));
		send(noise_cmd(MODE_RUN));

		set_vertex_count(0);
		send(arc_cmd(0, 0, -1));
		send(source_cmd(0));
		send(noise_cmd(MODE_RUN));

		// Repeated strongly negative self-loops drive the distance to saturation.
		set_vertex_count(127);
		send(source_cmd(0));
		for (int i = 0; i < 5; i++)
			send(arc_cmd(0, 0, 32'sh80000000));
		send(noise_cmd(MODE_RUN));

		for (int p = 0; p < 6; p++)
			random_phase(p >= 4);

		drain();
		repeat (30)
			@(posedge clk);
		if (fails == 0)
			$display("PASS bellman_ford_shortest_paths");
		else
			$display("FAIL bellman_ford_shortest_paths");
		$finish;
	end

endmodule

// ===== bellman_ford_shortest_paths.f =====
rtl/bfsp_pkg.sv
rtl/bfsp_edge_mem.sv
rtl/bfsp_vert_mem.sv
rtl/bellman_ford_shortest_paths.sv
tb/bfsp_checker.sv
tb/bellman_ford_shortest_paths_test.sv
